FILE: src/ftoa_pkg.sv
// Shared constants, command codes and status types for the float to decimal string core.
package ftoa_pkg;

   localparam int MAX_FRAC_DIGITS_DEF = 16;
   localparam int FRAC_BITS_DEF       = 64;

   localparam int FLOAT_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int CFG_W      = 5;
   localparam int INT_BITS   = 31;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int BCD_CNT_W  = $clog2(BCD_DIGITS + 1);
   localparam int CONV_CNT_W = $clog2(INT_BITS);

   localparam logic [INT_BITS-1:0] SAT_VALUE         = '1;
   localparam logic [CFG_W-1:0]    FRAC_DIGITS_RESET = 5'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;

   typedef enum logic [1:0] {
      BCD_HOLD,
      BCD_LOAD,
      BCD_DABBLE,
      BCD_SHIFT
   } bcd_cmd_type;

   typedef enum logic [1:0] {
      FRAC_HOLD,
      FRAC_LOAD,
      FRAC_STEP
   } frac_cmd_type;

   typedef struct packed {
      logic                neg;
      logic                oor;
      logic [INT_BITS-1:0] ipart;
   } unpack_type;

   typedef struct packed {
      logic [3:0]           top_digit;
      logic [BCD_CNT_W-1:0] count;
   } bcd_stat_type;

endpackage

FILE: src/float_to_decimal_string_core.sv
// Top level: sequencer, configuration register and output register of the float to string core.
// Converts one IEEE single-precision pattern to ASCII: optional '-', integer digits
// (truncated, "0" when zero, saturated to 2147483647 with rsp_tuser set for
// magnitudes of 2^31 or more, infinity and NaN), '.', then fraction_digits fraction
// digits (capped at MAX_FRAC_DIGITS), truncated from a FRAC_BITS binary fraction.
// After a request is taken the core shifts every integer bit through the binary-to-BCD
// register, drops leading zero digits (up to 9, keeping at least one), then emits the
// characters in order, waiting whenever the output side stalls. req_tready is high only
// between values; the final character may still wait in the output register while the
// next request is taken.
module float_to_decimal_string_core #(
   parameter int MAX_FRAC_DIGITS = ftoa_pkg::MAX_FRAC_DIGITS_DEF,
   parameter int FRAC_BITS       = ftoa_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ftoa_pkg::FLOAT_W-1:0]  req_tdata,   // [31:0] float_bits
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ftoa_pkg::CHAR_W-1:0]   rsp_tdata,   // [7:0] out_char
   output logic                          rsp_tlast,   // last_char
   output logic                          rsp_tuser,   // [0] out_of_range
   input  logic                          csr_we,
   input  logic [ftoa_pkg::CFG_W-1:0]    csr_wdata    // fraction_digits
);
   import ftoa_pkg::*;

   localparam int DCNT_W = $clog2(MAX_FRAC_DIGITS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_TRIM,
      S_SIGN,
      S_INT,
      S_POINT,
      S_FRAC
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      fdig_ff, fdig_in;
   logic [CONV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic                  neg_ff, neg_in;
   logic                  oor_ff, oor_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   unpack_type            info;
   logic [FRAC_BITS-1:0]  frac_init;
   bcd_cmd_type           bcd_cmd;
   bcd_stat_type          bcd_stat;
   frac_cmd_type          frac_cmd;
   logic [3:0]            frac_digit;
   logic                  accept;
   logic                  emit_ok;
   logic [DCNT_W-1:0]     ndig;

   ftoa_unpack #(.FRAC_BITS(FRAC_BITS)) u_unpack (
      .float_bits (req_tdata),
      .info       (info),
      .frac       (frac_init)
   );

   ftoa_bcd u_bcd (
      .clock (clock),
      .cmd   (bcd_cmd),
      .value (info.ipart),
      .stat  (bcd_stat)
   );

   ftoa_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
      .clock (clock),
      .cmd   (frac_cmd),
      .value (frac_init),
      .digit (frac_digit)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit_ok    = !rsp_valid_ff || rsp_tready;
   assign ndig       = (32'(fdig_ff) > MAX_FRAC_DIGITS) ? DCNT_W'(MAX_FRAC_DIGITS)
                                                        : DCNT_W'(fdig_ff);

   always_comb begin
      state_in     = state_ff;
      fdig_in      = csr_we ? csr_wdata : fdig_ff;
      cnt_in       = cnt_ff;
      dcnt_in      = dcnt_ff;
      neg_in       = neg_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_oor_in   = rsp_oor_ff;
      bcd_cmd      = BCD_HOLD;
      frac_cmd     = FRAC_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               bcd_cmd  = BCD_LOAD;
               frac_cmd = FRAC_LOAD;
               neg_in   = info.neg;
               oor_in   = info.oor;
               cnt_in   = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            bcd_cmd = BCD_DABBLE;
            cnt_in  = cnt_ff + CONV_CNT_W'(1);
            if (cnt_ff == CONV_CNT_W'(INT_BITS - 1)) begin
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            if ((bcd_stat.top_digit == 4'd0) && (bcd_stat.count > BCD_CNT_W'(1))) begin
               bcd_cmd = BCD_SHIFT;
            end else begin
               state_in = neg_ff ? S_SIGN : S_INT;
            end
         end
         S_SIGN: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_oor_in   = oor_ff;
               state_in     = S_INT;
            end
         end
         S_INT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + {4'd0, bcd_stat.top_digit};
               rsp_last_in  = 1'b0;
               rsp_oor_in   = oor_ff;
               bcd_cmd      = BCD_SHIFT;
               if (bcd_stat.count == BCD_CNT_W'(1)) begin
                  state_in = S_POINT;
               end
            end
         end
         S_POINT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_POINT;
               rsp_last_in  = (ndig == '0);
               rsp_oor_in   = oor_ff;
               dcnt_in      = ndig;
               state_in     = (ndig == '0) ? S_IDLE : S_FRAC;
            end
         end
         S_FRAC: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + {4'd0, frac_digit};
               rsp_last_in  = (dcnt_ff == DCNT_W'(1));
               rsp_oor_in   = oor_ff;
               frac_cmd     = FRAC_STEP;
               dcnt_in      = dcnt_ff - DCNT_W'(1);
               if (dcnt_ff == DCNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fdig_ff      <= FRAC_DIGITS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fdig_ff      <= fdig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      dcnt_ff     <= dcnt_in;
      neg_ff      <= neg_in;
      oor_ff      <= oor_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_oor_ff;

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CONV))
      else $error("accepted request did not start conversion");

   a_conv_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV) |-> (cnt_ff < CONV_CNT_W'(INT_BITS)))
      else $error("conversion counter out of range");

   a_int_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INT) |-> (bcd_stat.count != '0) && (bcd_stat.top_digit <= 4'd9))
      else $error("integer digit register empty or not decimal");

   a_frac_digit_decimal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FRAC) |-> (frac_digit <= 4'd9) && (dcnt_ff != '0))
      else $error("fraction digit not decimal or count exhausted");

   a_last_ends_value: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FRAC) && emit_ok && (dcnt_ff == DCNT_W'(1)))
         |=> (state_ff == S_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("final fraction digit not marked last");

endmodule

FILE: src/ftoa_unpack.sv
// Float field decode into sign, saturated integer part and fixed-point fraction.
module ftoa_unpack #(
   parameter int FRAC_BITS = ftoa_pkg::FRAC_BITS_DEF
) (
   input  logic [ftoa_pkg::FLOAT_W-1:0] float_bits,
   output ftoa_pkg::unpack_type         info,
   output logic [FRAC_BITS-1:0]         frac
);
   import ftoa_pkg::*;

   logic                sign;
   logic [7:0]          expo;
   logic [22:0]         man;
   logic [23:0]         mant;
   logic [23:0]         mlow;
   logic [7:0]          rsh;
   logic [7:0]          lsh;
   logic                int_only;
   logic                big;
   logic [FRAC_BITS+23:0] ext;

   always_comb begin
      sign     = float_bits[31];
      expo     = float_bits[30:23];
      man      = float_bits[22:0];
      mant     = (expo == 8'd0) ? {1'b0, man} : {1'b1, man};
      int_only = (expo >= 8'd150);
      lsh      = expo - 8'd150;
      rsh      = (expo == 8'd0) ? 8'd149 : 8'd150 - expo;
      big      = (expo == 8'hff) || (int_only && (lsh >= 8'd8));
      mlow     = (rsh >= 8'd24) ? mant : (mant & ~(24'hff_ffff << rsh));
      ext      = {mlow, {FRAC_BITS{1'b0}}} >> rsh;

      info.neg = sign && (float_bits[30:0] != 31'd0) && !((expo == 8'hff) && (man != 23'd0));
      info.oor = big;
      if (big) begin
         info.ipart = SAT_VALUE;
         frac       = '0;
      end else if (int_only) begin
         info.ipart = {7'd0, mant} << lsh[2:0];
         frac       = '0;
      end else begin
         info.ipart = INT_BITS'(mant >> rsh);
         frac       = ext[FRAC_BITS-1:0];
      end
   end

endmodule

FILE: src/ftoa_bcd.sv
// Shift-and-add-3 binary to BCD converter with digit shift-out.
module ftoa_bcd (
   input  logic                          clock,
   input  ftoa_pkg::bcd_cmd_type         cmd,
   input  logic [ftoa_pkg::INT_BITS-1:0] value,
   output ftoa_pkg::bcd_stat_type        stat
);
   import ftoa_pkg::*;

   logic [INT_BITS-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BCD_CNT_W-1:0] count_ff, count_in;
   logic [BCD_W-1:0]     adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      case (cmd)
         BCD_LOAD: begin
            bin_in   = value;
            bcd_in   = '0;
            count_in = BCD_CNT_W'(BCD_DIGITS);
         end
         BCD_DABBLE: begin
            bcd_in = {adj[BCD_W-2:0], bin_ff[INT_BITS-1]};
            bin_in = bin_ff << 1;
         end
         BCD_SHIFT: begin
            bcd_in   = bcd_ff << 4;
            count_in = count_ff - BCD_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
   end

   assign stat.top_digit = bcd_ff[BCD_W-1 -: 4];
   assign stat.count     = count_ff;

endmodule

FILE: src/ftoa_frac.sv
// Fraction register with times-ten step; each step yields one decimal digit.
module ftoa_frac #(
   parameter int FRAC_BITS = ftoa_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  ftoa_pkg::frac_cmd_type cmd,
   input  logic [FRAC_BITS-1:0]   value,
   output logic [3:0]             digit
);
   import ftoa_pkg::*;

   localparam int P_W = FRAC_BITS + 4;

   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [P_W-1:0]       prod;

   always_comb begin
      prod  = ({4'd0, frac_ff} << 3) + ({4'd0, frac_ff} << 1);
      digit = prod[P_W-1 -: 4];
      case (cmd)
         FRAC_LOAD: frac_in = value;
         FRAC_STEP: frac_in = prod[FRAC_BITS-1:0];
         default:   frac_in = frac_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
   end

endmodule

FILE: tb/float_to_decimal_string_checker.sv
// Checker for the float to decimal string core: predicts each character string and compares.
module float_to_decimal_string_checker
   import ftoa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [FLOAT_W-1:0] req_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [CHAR_W-1:0]  rsp_tdata,
   input  logic               rsp_tlast,
   input  logic               rsp_tuser,
   input  logic               csr_we,
   input  logic [CFG_W-1:0]   csr_wdata,
   output int                 outstanding,
   output int                 error_count,
   output int                 char_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_DIGITS_MAX = MAX_FRAC_DIGITS_DEF;
   localparam int FRAC_W          = FRAC_BITS_DEF;

   typedef struct packed {
      logic [FLOAT_W-1:0] src;
      logic [CHAR_W-1:0]  ch;
      logic               last;
      logic               oor;
   } char_rec_type;

   char_rec_type     pending_chars[$];
   logic [CFG_W-1:0] frac_digits = FRAC_DIGITS_RESET;

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void predict_string(input logic [FLOAT_W-1:0] bits);
      logic [7:0]        expo;
      logic [22:0]       man;
      logic [23:0]       sig;
      logic [63:0]       wide;
      logic [31:0]       ipart;
      logic [FRAC_W-1:0] frac;
      logic [FRAC_W+3:0] prod;
      logic [3:0]        digs[10];
      logic              oor;
      logic              neg;
      int                e;
      int                i;
      int                nd;
      int                ndig;
      char_rec_type      line[$];

      expo  = bits[30:23];
      man   = bits[22:0];
      neg   = bits[31] && (bits[30:0] != '0) && !(expo == 8'hFF && man != '0);
      oor   = 1'b0;
      ipart = '0;
      frac  = '0;
      if (expo == 8'hFF) begin
         oor = 1'b1;
      end else begin
         if (expo == 8'h00) begin
            sig = {1'b0, man};
            e   = -149;
         end else begin
            sig = {1'b1, man};
            e   = int'(expo) - 150;
         end
         if (e >= 8) begin
            oor = 1'b1;
         end else if (e >= 0) begin
            wide = 64'(sig) << e;
            if (wide >= 64'h8000_0000) oor = 1'b1;
            else ipart = wide[31:0];
         end else begin
            ipart = (-e >= 32) ? 32'd0 : (32'(sig) >> (-e));
            for (i = 0; i < 24 && i < -e; i++) begin
               if (sig[i] && (FRAC_W + e + i) >= 0) frac[FRAC_W + e + i] = 1'b1;
            end
         end
      end
      if (oor) begin
         ipart = {1'b0, SAT_VALUE};
         frac  = '0;
      end

      if (neg) line.push_back('{src: bits, ch: CHAR_MINUS, last: 1'b0, oor: oor});
      nd = 0;
      do begin
         digs[nd] = 4'(ipart % 10);
         ipart    = ipart / 10;
         nd++;
      end while (ipart != 0 && nd < 10);
      for (i = nd - 1; i >= 0; i--) begin
         line.push_back('{src: bits, ch: CHAR_ZERO + {4'b0, digs[i]}, last: 1'b0, oor: oor});
      end
      line.push_back('{src: bits, ch: CHAR_POINT, last: 1'b0, oor: oor});

      ndig = (int'(frac_digits) > FRAC_DIGITS_MAX) ? FRAC_DIGITS_MAX : int'(frac_digits);
      for (i = 0; i < ndig; i++) begin
         prod = {4'b0, frac} * 10;
         frac = prod[FRAC_W-1:0];
         line.push_back('{src: bits, ch: CHAR_ZERO + {4'b0, prod[FRAC_W+3:FRAC_W]}, last: 1'b0,
                          oor: oor});
      end
      line[line.size() - 1].last = 1'b1;
      foreach (line[k]) pending_chars.push_back(line[k]);
   endfunction

   always @(posedge clock) begin
      char_rec_type want;
      if (reset) begin
         frac_digits = FRAC_DIGITS_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            char_count++;
            if (pending_chars.size() == 0) begin
               report($sformatf("unexpected character %02h", rsp_tdata));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_tdata !== want.ch)
                  report($sformatf("value %08h: char %02h, want %02h",
                                   want.src, rsp_tdata, want.ch));
               if (rsp_tlast !== want.last)
                  report($sformatf("value %08h char %02h: tlast %b, want %b",
                                   want.src, want.ch, rsp_tlast, want.last));
               if (rsp_tuser !== want.oor)
                  report($sformatf("value %08h char %02h: tuser %b, want %b",
                                   want.src, want.ch, rsp_tuser, want.oor));
            end
         end
         if (req_tvalid && req_tready) predict_string(req_tdata);
         if (csr_we) frac_digits = csr_wdata;
      end
      outstanding <= pending_chars.size();
   end

endmodule

FILE: tb/tb.sv
// Testbench top: clock, reset, float stimulus, output stalls, watchdog and verdict.
module tb;
   import ftoa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PER_SET = 21;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [FLOAT_W-1:0] req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b1;
   logic [CHAR_W-1:0]  rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_we     = 1'b0;
   logic [CFG_W-1:0]   csr_wdata  = '0;

   int outstanding;
   int error_count;
   int char_count;
   int stall_left = 0;
   int idle_cycles = 0;
   bit stall_mode = 1'b0;
   bit gap_mode = 1'b0;
   int values_sent = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   float_to_decimal_string_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   float_to_decimal_string_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .error_count (error_count),
      .char_count  (char_count)
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 9);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [FLOAT_W-1:0] random_float();
      int                 r;
      logic [FLOAT_W-1:0] v;
      r = $urandom_range(0, 99);
      v = $urandom();
      if (r < 30) begin
         v[30:23] = 8'($urandom_range(100, 157));
      end else if (r < 40) begin
         v[30:23] = 8'($urandom_range(156, 159));
      end else if (r < 50) begin
         v[30:23] = 8'h00;
      end else if (r < 56) begin
         v[30:23] = 8'hFF;
         if ($urandom_range(0, 1) == 0) v[22:0] = '0;
      end else if (r < 61) begin
         v[30:0] = '0;
      end else if (r < 72) begin
         v[30:23] = 8'($urandom_range(127, 150));
         v[10:0]  = '0;
      end
      return v;
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_mode && $urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         stall_left <= idle_len() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_value(input logic [FLOAT_W-1:0] v);
      int gap;
      req_tdata  <= v;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      values_sent++;
      gap = (gap_mode && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_digits(input logic [CFG_W-1:0] v);
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   logic [FLOAT_W-1:0] directed_values[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBFC0_0000, 32'h3DCC_CCCD,
      32'h3F00_0000, 32'h42F6_E979, 32'h4EFF_FFFF, 32'h4F00_0000, 32'hCF00_0000,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFC0_0001, 32'hFFFF_FFFF,
      32'h7F7F_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h8000_0001, 32'h0080_0000,
      32'h1F80_0000, 32'h1F00_0000, 32'h4AFF_FFFF, 32'h4B7F_FFFF, 32'h4B80_0000
   };

   logic [CFG_W-1:0] digit_settings[] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd10};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[i]) send_value(directed_values[i]);
      drain();

      foreach (digit_settings[s]) begin
         write_digits((s == digit_settings.size() - 1) ? CFG_W'($urandom_range(0, 31))
                                                         : digit_settings[s]);
         stall_mode = (s % 3) != 0;
         gap_mode   = (s % 2) != 0;
         for (int n = 0; n < RANDOM_PER_SET; n++) begin
            send_value(random_float());
            if ($urandom_range(0, 29) == 0) drain();
         end
         drain();
      end

      repeat (100) @(posedge clock);
      $display("Converted %0d float values (%0d directed) into %0d checked characters",
               values_sent, directed_values.size(), char_count);
      $display("Fraction digit counts covered: reset value, 0, 31, 1, 16, 17 and one random");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
